/* hdl/pat_pkg.sv */
// Shared types and constants for the PID altitude thrust controller.
`default_nettype none

package pat_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_GAIN_P  = 3'd1;
    localparam logic [2:0] REG_GAIN_I  = 3'd2;
    localparam logic [2:0] REG_GAIN_D  = 3'd3;
    localparam logic [2:0] REG_PERIOD  = 3'd4;
    localparam logic [2:0] REG_RATE    = 3'd5;
    localparam logic [2:0] REG_HOVER   = 3'd6;

    // Reset values of the timing registers
    localparam logic [16:0] PERIOD_RESET = 17'd655;
    localparam logic [15:0] RATE_RESET   = 16'd100;

    typedef struct packed {
        logic [31:0] target_altitude;
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [16:0] step_period;
        logic [15:0] loop_rate;
        logic [31:0] hover_thrust;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INC,
        ST_DER,
        ST_P_HI,
        ST_P_LO,
        ST_I_HI,
        ST_I_LO,
        ST_D_HI,
        ST_D_LO,
        ST_D_ADD,
        ST_FIN,
        ST_OUT
    } t_state;

    // Operand selection of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ERR_PERIOD,
        MUL_DIFF_RATE,
        MUL_P_HI,
        MUL_P_LO,
        MUL_I_HI,
        MUL_I_LO,
        MUL_D_HI,
        MUL_D_LO
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD_HI,
        ACC_ADD_LO
    } t_acc_op;

    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_INIT,
        SUM_ADD
    } t_sum_op;

    typedef struct packed {
        logic    ld_alt;
        logic    ld_err;
        logic    step_err;
        logic    upd_integ;
        logic    ld_deriv;
        t_mul_op mul_op;
        t_acc_op acc_op;
        t_sum_op sum_op;
        logic    ld_out;
    } t_ctrl;

endpackage

`default_nettype wire

/* hdl/pat_cfg_regs.sv */
// Configuration register file of the PID altitude thrust controller.
`default_nettype none

module pat_cfg_regs
    import pat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // Write one register per request; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_altitude <= '0;
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= '0;
            r_cfg.step_period     <= PERIOD_RESET;
            r_cfg.loop_rate       <= RATE_RESET;
            r_cfg.hover_thrust    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET: r_cfg.target_altitude <= i_cfg_data;
                REG_GAIN_P: r_cfg.gain_p          <= i_cfg_data;
                REG_GAIN_I: r_cfg.gain_i          <= i_cfg_data;
                REG_GAIN_D: r_cfg.gain_d          <= i_cfg_data;
                REG_PERIOD: r_cfg.step_period     <= i_cfg_data[16:0];
                REG_RATE:   r_cfg.loop_rate       <= i_cfg_data[15:0];
                REG_HOVER:  r_cfg.hover_thrust    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hdl/pat_seq.sv */
// Sequencer that steps the shared multiplier through one altitude request.
`default_nettype none

module pat_seq
    import pat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_ctrl     o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    t_ctrl  w_ctrl;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and datapath controls
    always_comb begin
        n_state = r_state;
        w_ctrl  = '{ld_alt: 1'b0, ld_err: 1'b0, step_err: 1'b0, upd_integ: 1'b0,
                    ld_deriv: 1'b0, mul_op: MUL_NONE, acc_op: ACC_NONE,
                    sum_op: SUM_NONE, ld_out: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_ctrl.ld_alt = 1'b1;
                    n_state       = ST_ERR;
                end
            end
            ST_ERR: begin
                w_ctrl.ld_err = 1'b1;
                w_ctrl.sum_op = SUM_INIT;
                n_state       = ST_INC;
            end
            ST_INC: begin
                w_ctrl.mul_op   = MUL_ERR_PERIOD;
                w_ctrl.step_err = 1'b1;
                n_state         = ST_DER;
            end
            ST_DER: begin
                w_ctrl.mul_op    = MUL_DIFF_RATE;
                w_ctrl.upd_integ = 1'b1;
                n_state          = ST_P_HI;
            end
            ST_P_HI: begin
                w_ctrl.mul_op   = MUL_P_HI;
                w_ctrl.ld_deriv = 1'b1;
                n_state         = ST_P_LO;
            end
            ST_P_LO: begin
                w_ctrl.mul_op = MUL_P_LO;
                w_ctrl.acc_op = ACC_LOAD_HI;
                n_state       = ST_I_HI;
            end
            ST_I_HI: begin
                w_ctrl.mul_op = MUL_I_HI;
                w_ctrl.acc_op = ACC_ADD_LO;
                n_state       = ST_I_LO;
            end
            ST_I_LO: begin
                w_ctrl.mul_op = MUL_I_LO;
                w_ctrl.acc_op = ACC_LOAD_HI;
                w_ctrl.sum_op = SUM_ADD;
                n_state       = ST_D_HI;
            end
            ST_D_HI: begin
                w_ctrl.mul_op = MUL_D_HI;
                w_ctrl.acc_op = ACC_ADD_LO;
                n_state       = ST_D_LO;
            end
            ST_D_LO: begin
                w_ctrl.mul_op = MUL_D_LO;
                w_ctrl.acc_op = ACC_LOAD_HI;
                w_ctrl.sum_op = SUM_ADD;
                n_state       = ST_D_ADD;
            end
            ST_D_ADD: begin
                w_ctrl.acc_op = ACC_ADD_LO;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                w_ctrl.sum_op = SUM_ADD;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free or being drained
                if (!r_out_vld || !i_out_stall) begin
                    w_ctrl.ld_out = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Set valid on a new result, drop it once taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_ctrl.ld_out) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_ctrl      = w_ctrl;

endmodule

`default_nettype wire

/* hdl/pat_dp.sv */
// Datapath of the PID altitude thrust controller around one shared multiplier.
`default_nettype none

module pat_dp
    import pat_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_ctrl       i_ctrl,
    input  wire logic [31:0] i_alt,
    output logic [31:0]      o_thrust
);

    logic signed [31:0] r_alt;
    logic signed [31:0] r_err;
    logic signed [31:0] r_prev;
    logic signed [32:0] r_diff;
    logic signed [47:0] r_integ;
    logic signed [49:0] r_deriv;
    logic signed [58:0] r_prod;
    logic signed [82:0] r_acc;
    logic signed [65:0] r_sum;
    logic        [31:0] r_out;

    logic signed [32:0] w_err_raw;
    logic signed [31:0] w_err;
    logic signed [49:0] w_b_src;
    logic signed [32:0] w_mul_a;
    logic signed [25:0] w_mul_b;
    logic signed [58:0] w_prod;
    logic signed [58:0] w_inc;
    logic signed [59:0] w_int_sum;
    logic signed [47:0] w_integ;
    logic signed [82:0] w_shift;
    logic signed [61:0] w_term;
    logic        [31:0] w_out;

    // Saturate the setpoint error to 32 bits
    always_comb begin
        w_err_raw = $signed({i_cfg.target_altitude[31], i_cfg.target_altitude})
                  - $signed({r_alt[31], r_alt});
        if (w_err_raw[32] != w_err_raw[31]) begin
            w_err = w_err_raw[32] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
        end else begin
            w_err = w_err_raw[31:0];
        end
    end

    // Pick the wide operand that a gain multiplies
    always_comb begin
        case (i_ctrl.mul_op)
            MUL_P_HI, MUL_P_LO: w_b_src = {{18{r_err[31]}}, r_err};
            MUL_I_HI, MUL_I_LO: w_b_src = {{2{r_integ[47]}}, r_integ};
            MUL_D_HI, MUL_D_LO: w_b_src = r_deriv;
            default:            w_b_src = '0;
        endcase
    end

    // Operand select of the shared multiplier
    always_comb begin
        case (i_ctrl.mul_op)
            MUL_ERR_PERIOD: begin
                w_mul_a = {r_err[31], r_err};
                w_mul_b = $signed({9'd0, i_cfg.step_period});
            end
            MUL_DIFF_RATE: begin
                w_mul_a = r_diff;
                w_mul_b = $signed({10'd0, i_cfg.loop_rate});
            end
            MUL_P_HI: begin
                w_mul_a = $signed({i_cfg.gain_p[31], i_cfg.gain_p});
                w_mul_b = w_b_src[49:24];
            end
            MUL_P_LO: begin
                w_mul_a = $signed({i_cfg.gain_p[31], i_cfg.gain_p});
                w_mul_b = $signed({2'b00, w_b_src[23:0]});
            end
            MUL_I_HI: begin
                w_mul_a = $signed({i_cfg.gain_i[31], i_cfg.gain_i});
                w_mul_b = w_b_src[49:24];
            end
            MUL_I_LO: begin
                w_mul_a = $signed({i_cfg.gain_i[31], i_cfg.gain_i});
                w_mul_b = $signed({2'b00, w_b_src[23:0]});
            end
            MUL_D_HI: begin
                w_mul_a = $signed({i_cfg.gain_d[31], i_cfg.gain_d});
                w_mul_b = w_b_src[49:24];
            end
            MUL_D_LO: begin
                w_mul_a = $signed({i_cfg.gain_d[31], i_cfg.gain_d});
                w_mul_b = $signed({2'b00, w_b_src[23:0]});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = 59'(w_mul_a) * 59'(w_mul_b);

    // Integral update, saturated to 48 bits
    always_comb begin
        w_inc     = r_prod >>> FRAC_BITS;
        w_int_sum = $signed({{12{r_integ[47]}}, r_integ}) + $signed({w_inc[58], w_inc});
        if ((&w_int_sum[59:47]) || !(|w_int_sum[59:47])) begin
            w_integ = w_int_sum[47:0];
        end else if (w_int_sum[59]) begin
            w_integ = $signed({1'b1, 47'd0});
        end else begin
            w_integ = $signed({1'b0, {47{1'b1}}});
        end
    end

    // Scale the full gain product and saturate it to 62 bits
    always_comb begin
        w_shift = r_acc >>> FRAC_BITS;
        if ((&w_shift[82:61]) || !(|w_shift[82:61])) begin
            w_term = w_shift[61:0];
        end else if (w_shift[82]) begin
            w_term = $signed({1'b1, 61'd0});
        end else begin
            w_term = $signed({1'b0, {61{1'b1}}});
        end
    end

    // Saturate the command to 32 bits
    always_comb begin
        if ((&r_sum[65:31]) || !(|r_sum[65:31])) begin
            w_out = r_sum[31:0];
        end else if (r_sum[65]) begin
            w_out = {1'b1, 31'd0};
        end else begin
            w_out = {1'b0, {31{1'b1}}};
        end
    end

    // Controller state: previous error and integral
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (i_ctrl.step_err) begin
                r_prev <= r_err;
            end
            if (i_ctrl.upd_integ) begin
                r_integ <= w_integ;
            end
        end
    end

    // Working registers of one request
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctrl.ld_alt) begin
            r_alt <= i_alt;
        end
        if (i_ctrl.ld_err) begin
            r_err <= w_err;
        end
        if (i_ctrl.step_err) begin
            r_diff <= $signed({r_err[31], r_err}) - $signed({r_prev[31], r_prev});
        end
        if (i_ctrl.ld_deriv) begin
            r_deriv <= r_prod[49:0];
        end
        case (i_ctrl.acc_op)
            ACC_LOAD_HI: r_acc <= $signed({r_prod, 24'd0});
            ACC_ADD_LO:  r_acc <= r_acc + $signed({{24{r_prod[58]}}, r_prod});
            default: ;
        endcase
        case (i_ctrl.sum_op)
            SUM_INIT: r_sum <= $signed({{34{i_cfg.hover_thrust[31]}}, i_cfg.hover_thrust});
            SUM_ADD:  r_sum <= r_sum + $signed({{4{w_term[61]}}, w_term});
            default: ;
        endcase
        if (i_ctrl.ld_out) begin
            r_out <= w_out;
        end
    end

    assign o_thrust = r_out;

endmodule

`default_nettype wire

/* hdl/pid_altitude_thrust_top.sv */
// PID altitude controller with hover feedforward, one thrust command per sample.
// A new altitude is accepted only in idle, once the previous command has been
//   loaded into the output register; that load waits while a finished command sits
//   on a stalled output. The single multiplier issues eight products per sample
//   under the sequencer, plus load and saturation steps.
// Reset (synchronous, active low) restores register defaults and clears the
//   previous error, the integral and the output valid.
`default_nettype none

module pid_altitude_thrust_top
    import pat_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_measured_altitude,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_thrust_command
);

    t_cfg  w_cfg;
    t_ctrl w_ctrl;

    pat_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pat_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctrl      (w_ctrl)
    );

    pat_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_ctrl   (w_ctrl),
        .i_alt    (i_measured_altitude),
        .o_thrust (o_thrust_command)
    );

endmodule

`default_nettype wire
